// ===== hw/rtl/serp_pkg.sv =====
`timescale 1ns / 1ps

package serp_pkg;

  // Matrix geometry.
  localparam int MATRIX_WIDTH  = 32;
  localparam int MATRIX_HEIGHT = 32;
  localparam int MATRIX_MAX    = (MATRIX_WIDTH > MATRIX_HEIGHT) ? MATRIX_WIDTH : MATRIX_HEIGHT;

  // Column and row counters never hold more than the larger dimension minus one.
  localparam int CNT_W  = (MATRIX_MAX > 2) ? $clog2(MATRIX_MAX) : 1;
  localparam int ADDR_W = 12;
  localparam int TIME_W = 16;
  localparam int DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Rotation codes.
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;

  // Colour slots.
  localparam logic [1:0] SLOT_LAST = 2'd2;

  // Input opcodes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_THIRD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;

  // Reset values of the registers.
  localparam logic [1:0]        ROTATION_RESET    = ROT_180;
  localparam logic [1:0]        SLOT_FIRST_RESET  = 2'd1;
  localparam logic [1:0]        SLOT_SECOND_RESET = 2'd0;
  localparam logic [1:0]        SLOT_THIRD_RESET  = 2'd2;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET     = 16'd5000;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic              write_enable;
    logic              write_bank;
    logic [ADDR_W-1:0] write_address;
    logic [DATA_W-1:0] write_data;
    logic              frame_done;
    logic              timeout_fired;
  } result_t;

endpackage

// ===== hw/rtl/serp_addr.sv =====
`timescale 1ns / 1ps

module serp_addr (
  input  logic [serp_pkg::CNT_W-1:0]  column,
  input  logic [serp_pkg::CNT_W-1:0]  row,
  input  logic [1:0]                  mode,
  input  logic [1:0]                  slot,
  output logic [serp_pkg::ADDR_W-1:0] address
);

  // All arithmetic is modulo the address width, which matches the masked address.
  localparam logic [serp_pkg::ADDR_W-1:0] W = serp_pkg::ADDR_W'(serp_pkg::MATRIX_WIDTH);
  localparam logic [serp_pkg::ADDR_W-1:0] H = serp_pkg::ADDR_W'(serp_pkg::MATRIX_HEIGHT);

  logic [serp_pkg::ADDR_W-1:0] x;
  logic [serp_pkg::ADDR_W-1:0] y;
  logic [serp_pkg::ADDR_W-1:0] r;
  logic [serp_pkg::ADDR_W-1:0] pixel;

  assign x = serp_pkg::ADDR_W'(column);
  assign y = serp_pkg::ADDR_W'(row);
  assign r = H - 12'd1 - y;

  // Serpentine pixel index for the selected rotation.
  always_comb begin
    unique case (mode)
      serp_pkg::ROT_90: begin
        if (!x[0]) begin
          pixel = x * W + (W - 12'd1 - y);
        end else begin
          pixel = x * W + y;
        end
      end
      serp_pkg::ROT_180: begin
        if (!r[0]) begin
          pixel = r * W + (W - 12'd1 - x);
        end else begin
          pixel = r * W + x;
        end
      end
      default: begin
        if (!y[0]) begin
          pixel = y * W + x;
        end else begin
          pixel = y * W + (W - 12'd1 - x);
        end
      end
    endcase
  end

  // Three bytes per pixel, plus the colour slot.
  assign address = pixel * 12'd3 + serp_pkg::ADDR_W'(slot);

endmodule

// ===== hw/rtl/serpentine_pixel_address_mapper_top.sv =====
`timescale 1ns / 1ps

// Maps a stream of colour bytes for a zig-zag wired LED matrix onto frame-buffer
// byte addresses, one result beat for every input beat. A data beat yields a
// write of its byte to the bank being filled, at the pixel index for the current
// column and row (after the selected rotation) times three plus the colour slot;
// the beat that completes a frame sets frame_done and the other bank is filled
// next. A tick beat counts the idle timer down; when it expires the position
// counters restart and timeout_fired is set. Each beat is processed as it is
// accepted and its result waits in the output register, so a new beat can be
// taken every cycle while the result side keeps up. Configuration writes are
// always accepted and should be made while the block is idle.
module serpentine_pixel_address_mapper_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  serp_pkg::item_t                     item_data,
  output logic                                result_valid,
  input  logic                                result_ready,
  output serp_pkg::result_t                   result_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [serp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [serp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = serp_pkg::CNT_W;
  localparam logic [CW:0] WIDTH_LIM  = (CW + 1)'(serp_pkg::MATRIX_WIDTH);
  localparam logic [CW:0] HEIGHT_LIM = (CW + 1)'(serp_pkg::MATRIX_HEIGHT);

  // Configuration registers.
  logic [1:0]                  rotation_mode;
  logic [1:0]                  color_slot_first;
  logic [1:0]                  color_slot_second;
  logic [1:0]                  color_slot_third;
  logic [serp_pkg::TIME_W-1:0] timeout_ms;

  // Position and timer state.
  logic [1:0]                  color_count;
  logic [CW-1:0]               column_count;
  logic [CW-1:0]               row_count;
  logic                        fill_bank;
  logic [serp_pkg::TIME_W-1:0] idle_remaining;

  logic [1:0]                  color_count_next;
  logic [CW-1:0]               column_count_next;
  logic [CW-1:0]               row_count_next;
  logic                        fill_bank_next;
  logic [serp_pkg::TIME_W-1:0] idle_remaining_next;
  serp_pkg::result_t           result_next;

  logic                        accept;
  logic [1:0]                  mode;
  logic [1:0]                  slot_raw;
  logic [1:0]                  slot;
  logic [CW:0]                 col_lim;
  logic [CW:0]                 row_lim;
  logic [CW:0]                 col_inc;
  logic [CW:0]                 row_inc;
  logic [serp_pkg::TIME_W-1:0] idle_dec;
  logic [serp_pkg::ADDR_W-1:0] address;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_mode     <= serp_pkg::ROTATION_RESET;
      color_slot_first  <= serp_pkg::SLOT_FIRST_RESET;
      color_slot_second <= serp_pkg::SLOT_SECOND_RESET;
      color_slot_third  <= serp_pkg::SLOT_THIRD_RESET;
      timeout_ms        <= serp_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        serp_pkg::REG_ROTATION:    rotation_mode     <= cfg_data[1:0];
        serp_pkg::REG_SLOT_FIRST:  color_slot_first  <= cfg_data[1:0];
        serp_pkg::REG_SLOT_SECOND: color_slot_second <= cfg_data[1:0];
        serp_pkg::REG_SLOT_THIRD:  color_slot_third  <= cfg_data[1:0];
        serp_pkg::REG_TIMEOUT:     timeout_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

  // The unused rotation code behaves as no rotation.
  assign mode    = (rotation_mode == serp_pkg::ROT_90 || rotation_mode == serp_pkg::ROT_180)
                   ? rotation_mode : serp_pkg::ROT_NONE;
  assign col_lim = (mode == serp_pkg::ROT_90) ? HEIGHT_LIM : WIDTH_LIM;
  assign row_lim = (mode == serp_pkg::ROT_90) ? WIDTH_LIM : HEIGHT_LIM;

  // Colour slot for this byte; slot code three behaves as the last slot.
  always_comb begin
    unique case (color_count)
      2'd0:    slot_raw = color_slot_first;
      2'd1:    slot_raw = color_slot_second;
      default: slot_raw = color_slot_third;
    endcase
  end
  assign slot = (slot_raw > serp_pkg::SLOT_LAST) ? serp_pkg::SLOT_LAST : slot_raw;

  serp_addr u_addr (
    .column  (column_count),
    .row     (row_count),
    .mode    (mode),
    .slot    (slot),
    .address (address)
  );

  assign col_inc  = (CW + 1)'(column_count) + 1'b1;
  assign idle_dec = idle_remaining - 1'b1;

  // State update and result for the accepted beat.
  always_comb begin
    color_count_next    = color_count;
    column_count_next   = column_count;
    row_count_next      = row_count;
    fill_bank_next      = fill_bank;
    idle_remaining_next = idle_remaining;
    row_inc             = (CW + 1)'(row_count);

    result_next               = '0;
    result_next.write_bank    = fill_bank;

    if (item_data.opcode == serp_pkg::OP_TICK) begin
      idle_remaining_next = idle_dec;
      if (idle_dec == '0) begin
        result_next.timeout_fired = 1'b1;
        color_count_next          = 2'd0;
        column_count_next         = '0;
        row_count_next            = '0;
        idle_remaining_next       = timeout_ms;
      end
    end else begin
      idle_remaining_next       = timeout_ms;
      result_next.write_enable  = 1'b1;
      result_next.write_address = address;
      result_next.write_data    = item_data.data_byte;

      // Step colour, then column, then row.
      if (color_count == 2'd2) begin
        color_count_next = 2'd0;
        if (col_inc >= col_lim) begin
          column_count_next = '0;
          row_inc           = (CW + 1)'(row_count) + 1'b1;
        end else begin
          column_count_next = col_inc[CW-1:0];
        end
      end else begin
        color_count_next = color_count + 2'd1;
      end
      row_count_next = row_inc[CW-1:0];

      // Frame complete: swap banks and restart.
      if (row_inc >= row_lim) begin
        fill_bank_next         = !fill_bank;
        color_count_next       = 2'd0;
        column_count_next      = '0;
        row_count_next         = '0;
        result_next.frame_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count    <= 2'd0;
      column_count   <= '0;
      row_count      <= '0;
      fill_bank      <= 1'b1;
      idle_remaining <= serp_pkg::TIMEOUT_RESET;
    end else if (accept) begin
      color_count    <= color_count_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      fill_bank      <= fill_bank_next;
      idle_remaining <= idle_remaining_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data <= result_next;
    end
  end

endmodule

// ===== dv/serp_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and register channels of the pixel address mapper.
// Every accepted item beat is mapped to the write it should cause, and every
// accepted result beat is compared field by field with the oldest such write.
module serp_checker
  import serp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  item_t                 item_data,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    frames_seen,
  output int                    timeouts_seen
);

  // Writes predicted but not yet seen on the result channel.
  result_t expected_writes[$];

  // Shadow copy of the registers.
  logic [1:0]        rot_sel;
  logic [1:0]        slot_first;
  logic [1:0]        slot_second;
  logic [1:0]        slot_third;
  logic [TIME_W-1:0] idle_reload;

  // Shadow copy of the position counters, bank and idle timer.
  int unsigned       colour_idx;
  int unsigned       col_pos;
  int unsigned       row_pos;
  logic              bank_sel;
  logic [TIME_W-1:0] idle_left;

  int errors = 0;
  int depth  = 0;
  int frames = 0;
  int fires  = 0;

  assign fail_count    = errors;
  assign pending       = depth;
  assign frames_seen   = frames;
  assign timeouts_seen = fires;

  // Physical LED index for a column and row, following the zig-zag wiring.
  function automatic int unsigned panel_index(int unsigned col, int unsigned row,
                                              logic [1:0] mode);
    int unsigned flip;
    if (mode == ROT_90) begin
      if (col[0] == 1'b0) return col * MATRIX_WIDTH + (MATRIX_WIDTH - 1 - row);
      return col * MATRIX_WIDTH + row;
    end
    if (mode == ROT_180) begin
      flip = MATRIX_HEIGHT - 1 - row;
      if (flip[0] == 1'b0) return flip * MATRIX_WIDTH + (MATRIX_WIDTH - 1 - col);
      return flip * MATRIX_WIDTH + col;
    end
    if (row[0] == 1'b0) return row * MATRIX_WIDTH + col;
    return row * MATRIX_WIDTH + (MATRIX_WIDTH - 1 - col);
  endfunction

  // A slot code above the last slot behaves as the last slot.
  function automatic logic [1:0] slot_for(logic [1:0] code);
    return (code > SLOT_LAST) ? SLOT_LAST : code;
  endfunction

  // Works out the result of one item beat and advances the shadow state.
  task automatic map_beat(input item_t beat, output result_t res);
    logic [1:0]  mode;
    logic [1:0]  slot;
    int unsigned col_lim;
    int unsigned row_lim;
    int unsigned addr;
    res = '0;
    res.write_bank = bank_sel;
    if (beat.opcode == OP_TICK) begin
      idle_left = idle_left - 1'b1;
      if (idle_left == '0) begin
        res.timeout_fired = 1'b1;
        colour_idx = 0;
        col_pos    = 0;
        row_pos    = 0;
        idle_left  = idle_reload;
        fires++;
      end
      return;
    end

    idle_left = idle_reload;
    mode    = (rot_sel > ROT_180) ? ROT_NONE : rot_sel;
    col_lim = (mode == ROT_90) ? MATRIX_HEIGHT : MATRIX_WIDTH;
    row_lim = (mode == ROT_90) ? MATRIX_WIDTH : MATRIX_HEIGHT;
    if (colour_idx == 0)      slot = slot_for(slot_first);
    else if (colour_idx == 1) slot = slot_for(slot_second);
    else                      slot = slot_for(slot_third);
    addr = panel_index(col_pos, row_pos, mode) * 3 + slot;

    res.write_enable  = 1'b1;
    res.write_address = addr[ADDR_W-1:0];
    res.write_data    = beat.data_byte;

    // Step colour, then column, then row; a full frame swaps the bank.
    colour_idx++;
    if (colour_idx >= 3) begin
      colour_idx = 0;
      col_pos++;
      if (col_pos >= col_lim) begin
        col_pos = 0;
        row_pos++;
      end
    end
    if (row_pos >= row_lim) begin
      bank_sel   = ~bank_sel;
      colour_idx = 0;
      col_pos    = 0;
      row_pos    = 0;
      res.frame_done = 1'b1;
      frames++;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // All three channels are sampled at the rising edge.
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      rot_sel     = ROTATION_RESET;
      slot_first  = SLOT_FIRST_RESET;
      slot_second = SLOT_SECOND_RESET;
      slot_third  = SLOT_THIRD_RESET;
      idle_reload = TIMEOUT_RESET;
      idle_left   = TIMEOUT_RESET;
      colour_idx  = 0;
      col_pos     = 0;
      row_pos     = 0;
      bank_sel    = 1'b1;
      expected_writes.delete();
      depth = 0;
    end else begin
      // A result cannot belong to an item accepted at the same edge, so compare first.
      if (result_valid && result_ready) begin
        if (expected_writes.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual %p", $time, result_data);
        end else begin
          want = expected_writes.pop_front();
          check_field("write_enable",  want.write_enable,  result_data.write_enable);
          check_field("write_bank",    want.write_bank,    result_data.write_bank);
          check_field("write_address", want.write_address, result_data.write_address);
          check_field("write_data",    want.write_data,    result_data.write_data);
          check_field("frame_done",    want.frame_done,    result_data.frame_done);
          check_field("timeout_fired", want.timeout_fired, result_data.timeout_fired);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROTATION:    rot_sel     = cfg_data[1:0];
          REG_SLOT_FIRST:  slot_first  = cfg_data[1:0];
          REG_SLOT_SECOND: slot_second = cfg_data[1:0];
          REG_SLOT_THIRD:  slot_third  = cfg_data[1:0];
          REG_TIMEOUT:     idle_reload = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end

      if (item_valid && item_ready) begin
        map_beat(item_data, want);
        expected_writes.push_back(want);
      end
      depth = expected_writes.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

// Drives colour bytes and millisecond ticks into the pixel address mapper under
// a range of register settings, with random gaps on both channels.
module tb;
  import serp_pkg::*;

  localparam int LIMIT        = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TOTAL_ITEMS  = 850;
  localparam int PHASE_ITEMS  = 120;
  // An index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_ready;
  item_t                 item_data    = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result_data;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int fail_count;
  int pending;
  int frames_seen;
  int timeouts_seen;
  int items_sent  = 0;
  int reg_writes  = 0;
  int quiet       = 0;
  bit steady_tx   = 1'b0;
  bit hold_req    = 1'b0;
  bit holding     = 1'b0;

  serpentine_pixel_address_mapper_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  serp_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item_data     (item_data),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_data   (result_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .frames_seen   (frames_seen),
    .timeouts_seen (timeouts_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly no gap, sometimes a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Result side: runs of ready with random stalls, plus one long hold on request.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        holding = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 250)) @(negedge clk);
        else repeat ($urandom_range(1, 20)) @(negedge clk);
        if (pick_gap() > 0) begin
          result_ready <= 1'b0;
          repeat (pick_gap() + 1) @(negedge clk);
        end
      end
    end
  end

  // Ends the run when nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back beats need no extra edge.
  task automatic push_item(input logic op, input logic [DATA_W-1:0] value);
    item_t beat;
    int    gap;
    beat.opcode    = op;
    beat.data_byte = value;
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= beat;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [DATA_W-1:0] value);
    push_item(OP_DATA, value);
  endtask

  // A tick carries a random byte that the block must ignore.
  task automatic push_tick();
    push_item(OP_TICK, DATA_W'($urandom));
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic settle();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(negedge clk);
  endtask

  // Only called while the item channel is quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Slot and rotation writes carry random upper bits that must be ignored.
  task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] code);
    write_reg(idx, {14'($urandom), code});
  endtask

  initial begin
    int phase_len;
    int tick_pct;
    logic [1:0] frame_modes [3];

    frame_modes[0] = ROT_90;
    frame_modes[1] = ROT_NONE;
    frame_modes[2] = ROT_180;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: byte extremes, then a tick.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);
    push_tick();
    settle();

    // Unused rotation code, slot codes beyond the last, and a two-tick timeout.
    write_code(REG_ROTATION, 2'd3);
    write_code(REG_SLOT_FIRST, 2'd3);
    write_code(REG_SLOT_SECOND, 2'd2);
    write_code(REG_SLOT_THIRD, 2'd0);
    write_reg(REG_TIMEOUT, 16'd2);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    push_byte(8'h44);
    settle();

    // Timeout of zero wraps the countdown; a register write does not reload it.
    write_reg(REG_TIMEOUT, 16'd0);
    push_byte(8'h80);
    push_tick();
    settle();
    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_UNUSED, 16'hFFFF);
    push_tick();
    push_byte(8'h01);
    push_tick();
    settle();

    // Quarter turn, a few bytes.
    write_code(REG_ROTATION, ROT_90);
    write_code(REG_SLOT_FIRST, 2'd0);
    write_code(REG_SLOT_SECOND, 2'd1);
    write_code(REG_SLOT_THIRD, 2'd3);
    push_byte(8'hC3);
    push_byte(8'h3C);
    push_byte(8'h7E);
    push_byte(8'h81);
    settle();

    // A run of bytes in each rotation with sparse ticks and a long timeout; the
    // middle run is sent without gaps while the result side holds off.
    for (int m = 0; m < 3; m++) begin
      write_code(REG_ROTATION, frame_modes[m]);
      write_code(REG_SLOT_FIRST, 2'($urandom_range(0, 3)));
      write_code(REG_SLOT_SECOND, 2'($urandom_range(0, 3)));
      write_code(REG_SLOT_THIRD, 2'($urandom_range(0, 3)));
      write_reg(REG_TIMEOUT, (m == 0) ? 16'hFFFF : 16'($urandom_range(4000, 65535)));
      if (m == 1) begin
        steady_tx = 1'b1;
        hold_req  = 1'b1;
        wait (holding);
        hold_req  = 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 15) == 0) push_tick();
        push_byte(DATA_W'($urandom));
      end
      settle();
      steady_tx = 1'b0;
    end

    // Random settings, mostly short timeouts, with a mix of bytes and ticks.
    while (items_sent < TOTAL_ITEMS) begin
      write_code(REG_ROTATION, 2'($urandom_range(0, 3)));
      write_code(REG_SLOT_FIRST, 2'($urandom_range(0, 3)));
      write_code(REG_SLOT_SECOND, 2'($urandom_range(0, 3)));
      write_code(REG_SLOT_THIRD, 2'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) < 7) write_reg(REG_TIMEOUT, 16'($urandom_range(1, 12)));
      else write_reg(REG_TIMEOUT, 16'($urandom));
      steady_tx = ($urandom_range(0, 4) == 0);
      tick_pct  = $urandom_range(10, 70);
      phase_len = $urandom_range(40, 120);
      for (int n = 0; n < phase_len; n++) begin
        if ($urandom_range(0, 99) < tick_pct) push_tick();
        else push_byte(DATA_W'($urandom));
      end
      settle();
      steady_tx = 1'b0;
    end

    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d item beats over %0d register writes in all rotations and slot maps.",
             items_sent, reg_writes);
    $display("Saw %0d completed frames and %0d idle timeouts.", frames_seen, timeouts_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
